// ===== hw/rtl/fpsc_pkg.sv =====
// Shared types and constants for the fractional PLL setting calculator.
// Used by fpsc_div and fractional_pll_setting_calculator; no dependencies.
package fpsc_pkg;

  localparam int W = 27;
  localparam int REF_W = 26;
  localparam int CNT_W = $clog2(W);

  localparam logic [W-1:0] PFD_MAX_HZ  = W'(13500000);
  localparam logic [W-1:0] PFD_MAX_HZ2 = W'(27000000);
  localparam logic [W-1:0] PFD_MAX_HZ3 = W'(40500000);
  localparam logic [W-1:0] PFD_MAX_HZ4 = W'(54000000);
  localparam logic [W-1:0] NM_MAX      = W'(16'hffff);
  localparam logic [W-1:0] R_MAX       = W'(8);
  localparam logic [W-1:0] R_MIN       = W'(2);
  localparam logic [2:0]   D_MAX       = 3'd4;
  localparam logic [REF_W-1:0] REF_RESET = REF_W'(12288000);

  typedef struct packed {
    logic         done;
    logic [W-1:0] quotient;
    logic [W-1:0] remainder;
  } div_res_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV_INT,
    ST_DIV_FIN,
    ST_DIV_R,
    ST_GCD,
    ST_DIV_N,
    ST_DIV_M,
    ST_FINISH
  } state_t;

endpackage

// ===== hw/rtl/fpsc_div.sv =====
// Shared restoring divider, one quotient bit per cycle.
// Depends on fpsc_pkg for the operand width and the result struct.
module fpsc_div (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [fpsc_pkg::W-1:0] dividend,
  input  logic [fpsc_pkg::W-1:0] divisor,
  output fpsc_pkg::div_res_t   res
);
  import fpsc_pkg::*;

  logic             busy;
  logic             done;
  logic [CNT_W-1:0] count;
  logic [W-1:0]     quo;
  logic [W-1:0]     rem;
  logic [W:0]       partial;
  logic [W:0]       diff;

  always_comb begin
    partial = {rem, quo[W-1]};
    diff    = partial - {1'b0, divisor};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= CNT_W'(W - 1);
      end else if (busy) begin
        count <= count - 1'b1;
        if (count == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
    end else if (busy) begin
      if (!diff[W]) begin
        rem <= diff[W-1:0];
        quo <= {quo[W-2:0], 1'b1};
      end else begin
        rem <= partial[W-1:0];
        quo <= {quo[W-2:0], 1'b0};
      end
    end
  end

  assign res.done      = done;
  assign res.quotient  = quo;
  assign res.remainder = rem;

endmodule

// ===== hw/rtl/fractional_pll_setting_calculator.sv =====
// Top level of the fractional PLL setting calculator: sequencer and result register.
// Depends on fpsc_pkg and fpsc_div.
//
//   channel   signals                                        direction
//   input     in_valid, in_ready, target_hz                  in
//   config    ref_clock_we, ref_clock_hz                     in
//   output    out_valid, out_ready, denominator_m,
//             numerator_n, control_byte, enable_byte, failed out
//
// Every division runs on one shared divider. A zero target or zero reference
// needs no division, an integer ratio one, and a fractional ratio five divisions
// plus one per Euclid step, unless a check fails earlier.
// The input is taken only while the sequencer is idle; a finished transaction waits
// in the output register while the next input is accepted. Reset is synchronous.
module fractional_pll_setting_calculator (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [26:0] target_hz,
  input  logic        ref_clock_we,
  input  logic [25:0] ref_clock_hz,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] denominator_m,
  output logic [15:0] numerator_n,
  output logic [7:0]  control_byte,
  output logic        enable_byte,
  output logic        failed
);
  import fpsc_pkg::*;

  state_t         state, state_next;
  logic [REF_W-1:0] ref_clock;
  logic [W-1:0]   ref_ext;
  logic [W-1:0]   tgt, tgt_next;
  logic [W-1:0]   op_a, op_a_next;
  logic [W-1:0]   op_b, op_b_next;
  logic [W-1:0]   r_val, r_val_next;
  logic [W-1:0]   rem_val, rem_val_next;
  logic [W-1:0]   fin, fin_next;
  logic [W-1:0]   n_val, n_val_next;
  logic [W-1:0]   m_val, m_val_next;
  logic [1:0]     code, code_next;
  logic           fail, fail_next;
  logic           launch, launch_next;
  logic [2:0]     d_calc;
  logic           out_free;
  logic           fail_final;
  div_res_t       div_res;

  fpsc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (launch),
    .dividend (op_a),
    .divisor  (op_b),
    .res      (div_res)
  );

  assign ref_ext  = {1'b0, ref_clock};
  assign in_ready = (state == ST_IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    if (ref_ext <= PFD_MAX_HZ) begin
      d_calc = 3'd1;
    end else if (ref_ext <= PFD_MAX_HZ2) begin
      d_calc = 3'd2;
    end else if (ref_ext <= PFD_MAX_HZ3) begin
      d_calc = 3'd3;
    end else if (ref_ext <= PFD_MAX_HZ4) begin
      d_calc = 3'd4;
    end else begin
      d_calc = 3'd5;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_CHECK;
      end
      ST_CHECK: begin
        if (tgt == '0 || ref_clock == '0) state_next = ST_FINISH;
        else state_next = ST_DIV_INT;
      end
      ST_DIV_INT: begin
        if (div_res.done) begin
          if (div_res.remainder == '0 || d_calc > D_MAX) state_next = ST_FINISH;
          else state_next = ST_DIV_FIN;
        end
      end
      ST_DIV_FIN: begin
        if (div_res.done) state_next = ST_DIV_R;
      end
      ST_DIV_R: begin
        if (div_res.done) begin
          if (div_res.quotient > R_MAX || div_res.quotient < R_MIN) begin
            state_next = ST_FINISH;
          end else if (div_res.remainder == '0) begin
            state_next = ST_DIV_N;
          end else begin
            state_next = ST_GCD;
          end
        end
      end
      ST_GCD: begin
        if (div_res.done && div_res.remainder == '0) state_next = ST_DIV_N;
      end
      ST_DIV_N: begin
        if (div_res.done) state_next = ST_DIV_M;
      end
      ST_DIV_M: begin
        if (div_res.done) state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    tgt_next     = tgt;
    op_a_next    = op_a;
    op_b_next    = op_b;
    r_val_next   = r_val;
    rem_val_next = rem_val;
    fin_next     = fin;
    n_val_next   = n_val;
    m_val_next   = m_val;
    code_next    = code;
    fail_next    = fail;
    launch_next  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        tgt_next   = target_hz;
        r_val_next = '0;
        n_val_next = '0;
        m_val_next = '0;
        code_next  = '0;
        fail_next  = 1'b0;
      end
      ST_CHECK: begin
        if (tgt != '0) begin
          if (ref_clock == '0) begin
            fail_next = 1'b1;
          end else begin
            op_a_next   = tgt;
            op_b_next   = ref_ext;
            launch_next = 1'b1;
          end
        end
      end
      ST_DIV_INT: begin
        if (div_res.done) begin
          if (div_res.remainder == '0) begin
            r_val_next = div_res.quotient;
          end else if (d_calc > D_MAX) begin
            fail_next = 1'b1;
          end else begin
            code_next   = 2'(d_calc - 3'd1);
            op_a_next   = ref_ext;
            op_b_next   = W'(d_calc);
            launch_next = 1'b1;
          end
        end
      end
      ST_DIV_FIN: begin
        if (div_res.done) begin
          fin_next    = div_res.quotient;
          op_a_next   = tgt;
          op_b_next   = div_res.quotient;
          launch_next = 1'b1;
        end
      end
      ST_DIV_R: begin
        if (div_res.done) begin
          r_val_next   = div_res.quotient;
          rem_val_next = div_res.remainder;
          if (div_res.quotient > R_MAX || div_res.quotient < R_MIN) begin
            fail_next = 1'b1;
          end else if (div_res.remainder == '0) begin
            op_a_next   = '0;
            op_b_next   = fin;
            launch_next = 1'b1;
          end else begin
            op_a_next   = fin;
            op_b_next   = div_res.remainder;
            launch_next = 1'b1;
          end
        end
      end
      ST_GCD: begin
        if (div_res.done) begin
          if (div_res.remainder == '0) begin
            op_a_next = rem_val;
          end else begin
            op_a_next = op_b;
            op_b_next = div_res.remainder;
          end
          launch_next = 1'b1;
        end
      end
      ST_DIV_N: begin
        if (div_res.done) begin
          n_val_next  = div_res.quotient;
          op_a_next   = fin;
          launch_next = 1'b1;
        end
      end
      ST_DIV_M: begin
        if (div_res.done) m_val_next = div_res.quotient;
      end
      ST_FINISH: begin
      end
      default: begin
      end
    endcase
  end

  assign fail_final = fail || (tgt != '0 &&
                      (n_val > NM_MAX || m_val > NM_MAX ||
                       r_val > R_MAX || r_val < R_MIN));

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      launch    <= 1'b0;
      ref_clock <= REF_RESET;
      out_valid <= 1'b0;
    end else begin
      state  <= state_next;
      launch <= launch_next;
      if (ref_clock_we) ref_clock <= ref_clock_hz;
      if (state == ST_FINISH && out_free) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    tgt     <= tgt_next;
    op_a    <= op_a_next;
    op_b    <= op_b_next;
    r_val   <= r_val_next;
    rem_val <= rem_val_next;
    fin     <= fin_next;
    n_val   <= n_val_next;
    m_val   <= m_val_next;
    code    <= code_next;
    fail    <= fail_next;
    if (state == ST_FINISH && out_free) begin
      if (fail_final) begin
        denominator_m <= '0;
        numerator_n   <= '0;
        control_byte  <= '0;
        enable_byte   <= 1'b0;
        failed        <= 1'b1;
      end else begin
        denominator_m <= m_val[15:0];
        numerator_n   <= n_val[15:0];
        control_byte  <= {1'b0, r_val[3:0], code, (m_val != '0)};
        enable_byte   <= 1'b1;
        failed        <= 1'b0;
      end
    end
  end

endmodule

// ===== sim/tb_top.sv =====
// Self-checking testbench for fractional_pll_setting_calculator: a queue-fed driver,
// a result monitor and a built-in predictor of M, N and the control byte.
// Depends only on the RTL in hw/rtl (fpsc_pkg, fpsc_div and the top level).
module tb_top;

  localparam logic [31:0] PFD_LIMIT_HZ = 32'd13500000;
  localparam logic [31:0] NM_LIMIT     = 32'hffff;
  localparam logic [31:0] CODE_LIMIT   = 32'd3;
  localparam logic [31:0] R_HIGH       = 32'd8;
  localparam logic [31:0] R_LOW        = 32'd2;
  localparam logic [25:0] REF_AT_RESET = 26'd12288000;
  localparam int          PLANNED      = 1850;
  localparam int          HOLD_CYCLES  = 4000;
  localparam int          DRAIN_CYCLES = 1500;

  typedef struct packed {
    logic [15:0] m;
    logic [15:0] n;
    logic [7:0]  ctl;
    logic        en;
    logic        fail;
  } pll_word_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [26:0] target_hz = '0;
  logic        ref_clock_we = 1'b0;
  logic [25:0] ref_clock_hz = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [15:0] denominator_m;
  logic [15:0] numerator_n;
  logic [7:0]  control_byte;
  logic        enable_byte;
  logic        failed;

  logic [26:0] pending_q[$];
  pll_word_t   setting_q[$];
  logic [25:0] ref_model = REF_AT_RESET;
  logic        in_taken = 1'b0;
  int          n_accepted = 0;
  int          mismatch_cnt = 0;
  int          send_idle_pct;
  int          recv_idle_pct;
  int          hold_left = 0;
  logic        hold_done = 1'b0;

  fractional_pll_setting_calculator dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .target_hz    (target_hz),
    .ref_clock_we (ref_clock_we),
    .ref_clock_hz (ref_clock_hz),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .denominator_m(denominator_m),
    .numerator_n  (numerator_n),
    .control_byte (control_byte),
    .enable_byte  (enable_byte),
    .failed       (failed)
  );

  always #1 clk = ~clk;

  function automatic logic [31:0] divided_ref(input logic [25:0] ref_hz);
    logic [31:0] rf;
    logic [31:0] d;
    rf = 32'(ref_hz);
    d = (rf + PFD_LIMIT_HZ - 32'd1) / PFD_LIMIT_HZ;
    return (d == 0) ? 32'd0 : rf / d;
  endfunction

  function automatic pll_word_t pll_setting(input logic [26:0] tgt, input logic [25:0] ref_hz);
    logic [31:0] t32, rf, r, n, m, code, d, fin, rem, a, b, tmp;
    logic        fail;
    pll_word_t   w;
    t32 = 32'(tgt);
    rf = 32'(ref_hz);
    r = 0;
    n = 0;
    m = 0;
    code = 0;
    fail = 1'b0;
    if (t32 != 0) begin
      if (rf == 0) begin
        fail = 1'b1;
      end else if (t32 % rf != 0) begin
        d = (rf + PFD_LIMIT_HZ - 32'd1) / PFD_LIMIT_HZ;
        fin = rf / d;
        r = t32 / fin;
        rem = t32 % fin;
        a = rem;
        b = fin;
        while (b != 0) begin
          tmp = a % b;
          a = b;
          b = tmp;
        end
        n = rem / a;
        m = fin / a;
        code = d - 32'd1;
      end else begin
        r = t32 / rf;
      end
      if (!fail && (n > NM_LIMIT || m > NM_LIMIT || code > CODE_LIMIT ||
                    r > R_HIGH || r < R_LOW))
        fail = 1'b1;
    end
    w = '0;
    if (fail) begin
      w.fail = 1'b1;
    end else begin
      w.m = m[15:0];
      w.n = n[15:0];
      w.ctl = 8'((r << 3) | (code << 1) | ((m != 0) ? 32'd1 : 32'd0));
      w.en = 1'b1;
    end
    return w;
  endfunction

  // Builds a target of R times the divided reference plus a remainder that shares
  // a large factor with it, so that M and N often fit in 16 bits.
  function automatic logic [26:0] shaped_target(input logic [25:0] ref_hz);
    logic [63:0] fin, s, g, r, k, tgt;
    int          tries;
    fin = 64'(divided_ref(ref_hz));
    if (fin == 0)
      return 27'($urandom);
    s = 64'd1;
    for (tries = 0; tries < 40; tries++) begin
      k = (tries < 20) ? 64'($urandom_range(1, 64)) : 64'($urandom_range(1, 65535));
      if (k <= fin && fin % k == 0 && k > s)
        s = k;
    end
    g = fin / s;
    r = ($urandom_range(9) == 0) ? 64'($urandom_range(0, 10)) : 64'($urandom_range(2, 8));
    k = 64'($urandom_range(0, 32'(s - 1)));
    tgt = r * fin + g * k;
    return tgt[26:0];
  endfunction

  always_comb begin
    if (n_accepted < PLANNED / 3) begin
      send_idle_pct = 21;
      recv_idle_pct = 63;
    end else if (n_accepted < 2 * PLANNED / 3) begin
      send_idle_pct = 63;
      recv_idle_pct = 21;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        target_hz <= pending_q.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && n_accepted >= PLANNED - 350) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end
  end

  always @(negedge clk) begin
    out_ready <= !rst && hold_left == 0 && $urandom_range(99) >= recv_idle_pct;
  end

  always @(posedge clk) begin
    in_taken <= !rst && in_valid && in_ready;
    if (!rst && in_valid && in_ready) begin
      setting_q.push_back(pll_setting(target_hz, ref_model));
      n_accepted <= n_accepted + 1;
    end
  end

  always @(posedge clk) begin
    pll_word_t got;
    pll_word_t want;
    if (!rst && out_valid && out_ready) begin
      got = '{denominator_m, numerator_n, control_byte, enable_byte, failed};
      if (setting_q.size() == 0) begin
        mismatch_cnt <= mismatch_cnt + 1;
        if (mismatch_cnt < 10)
          $display("Unexpected transaction: m=%0d n=%0d ctl=%02h en=%0b fail=%0b",
                   got.m, got.n, got.ctl, got.en, got.fail);
      end else begin
        want = setting_q.pop_front();
        if (got !== want) begin
          mismatch_cnt <= mismatch_cnt + 1;
          if (mismatch_cnt < 10)
            $display("Mismatch: m=%0d/%0d n=%0d/%0d ctl=%02h/%02h en=%0b/%0b fail=%0b/%0b",
                     got.m, want.m, got.n, want.n, got.ctl, want.ctl,
                     got.en, want.en, got.fail, want.fail);
        end
      end
    end
  end

  task automatic wait_idle();
    while (pending_q.size() != 0 || in_valid || setting_q.size() != 0)
      @(negedge clk);
  endtask

  task automatic set_ref(input logic [25:0] value);
    wait_idle();
    ref_clock_hz <= value;
    ref_clock_we <= 1'b1;
    ref_model = value;
    @(negedge clk);
    ref_clock_we <= 1'b0;
  endtask

  task automatic add_random(input int count);
    int          i;
    int          kind;
    logic [31:0] mult;
    for (i = 0; i < count; i++) begin
      kind = $urandom_range(99);
      if (kind < 2) begin
        pending_q.push_back(27'd0);
      end else if (kind < 72) begin
        pending_q.push_back(shaped_target(ref_model));
      end else if (kind < 86) begin
        mult = $urandom_range(0, 10);
        pending_q.push_back(27'(mult * 32'(ref_model)));
      end else begin
        pending_q.push_back(27'($urandom));
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    pending_q.push_back(27'd0);
    pending_q.push_back(27'd24576000);
    pending_q.push_back(27'd12288000);
    pending_q.push_back(27'd110592000);
    pending_q.push_back(27'd98304000);
    pending_q.push_back(27'h7ffffff);
    pending_q.push_back(27'd1);
    pending_q.push_back(27'd30000000);
    add_random(250);

    set_ref(26'd0);
    pending_q.push_back(27'd0);
    pending_q.push_back(27'd5);
    pending_q.push_back(27'h7ffffff);
    add_random(40);

    set_ref(26'h3ffffff);
    pending_q.push_back(27'h7ffffff);
    pending_q.push_back(27'd134217726);
    add_random(60);

    set_ref(26'd54000000);
    pending_q.push_back(27'd121500000);
    pending_q.push_back(27'd40500000);
    pending_q.push_back(27'd27000001);
    add_random(200);

    set_ref(26'd20000000);
    pending_q.push_back(27'd30000000);
    pending_q.push_back(27'd27000000);
    add_random(200);

    set_ref(26'd1);
    pending_q.push_back(27'd5);
    pending_q.push_back(27'h7ffffff);
    add_random(60);

    set_ref(26'd13500000);
    add_random(200);
    set_ref(26'($urandom_range(1, 54000000)));
    add_random(250);
    set_ref(26'($urandom_range(1, 54000000)));
    add_random(250);
    set_ref(26'($urandom));
    add_random(150);
    set_ref(26'd11289600);
    add_random(200);

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_cnt == 0 && setting_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #40000000;
    $display("simulation failed");
    $finish;
  end

endmodule
